FILE: hw/rtl/cc20_pkg.sv
// Shared types and constants for the ChaCha20 stream cipher block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cc20_pkg;

    typedef logic [31:0] word_t;

    // Rotation applied by the quarter-round step unit.
    typedef enum logic [1:0] {
        ROT16,
        ROT12,
        ROT8,
        ROT7
    } rot_t;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CNT = 3'd5;

    localparam word_t SIGMA0 = 32'h61707865;
    localparam word_t SIGMA1 = 32'h3320646e;
    localparam word_t SIGMA2 = 32'h79622d32;
    localparam word_t SIGMA3 = 32'h6b206574;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_in;
    } plain_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
        logic       counter_wrapped;
    } crypt_t;

endpackage

FILE: hw/rtl/cc20_qr_unit.sv
// Shared quarter-round step: one 32-bit add, an XOR and a rotation by 16, 12, 8 or 7 bits.
// Depends on cc20_pkg.
`timescale 1ns / 1ps

module cc20_qr_unit (
    input  cc20_pkg::word_t x,
    input  cc20_pkg::word_t y,
    input  cc20_pkg::word_t z,
    input  cc20_pkg::rot_t  rot,
    output cc20_pkg::word_t sum,
    output cc20_pkg::word_t mixed
);
    import cc20_pkg::*;

    word_t mix_pre;

    assign sum     = x + y;
    assign mix_pre = z ^ sum;

    always_comb
    begin
        unique case (rot)
            ROT16:   mixed = {mix_pre[15:0], mix_pre[31:16]};
            ROT12:   mixed = {mix_pre[19:0], mix_pre[31:20]};
            ROT8:    mixed = {mix_pre[23:0], mix_pre[31:24]};
            ROT7:    mixed = {mix_pre[24:0], mix_pre[31:25]};
            default: mixed = mix_pre;
        endcase
    end

endmodule

FILE: hw/rtl/cc20_core.sv
// Block function sequencer: holds the 16-word state, drives the shared step
// unit through all rounds and the final add-back. Depends on cc20_pkg, cc20_qr_unit.
`timescale 1ns / 1ps

module cc20_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [255:0]          key,
    input  logic [63:0]           nonce,
    input  logic [63:0]           count,
    input  logic [5:0]            byte_sel,
    output logic [7:0]            byte_out,
    output logic                  done
);
    import cc20_pkg::*;

    localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } core_state_t;

    core_state_t     state_reg, state_next;
    word_t           w_reg [16];
    word_t           w_next [16];
    word_t           upd [16];
    word_t           init_w [16];
    logic [1:0]      step_reg, step_next;
    logic [1:0]      qr_reg, qr_next;
    logic            half_reg, half_next;
    logic [DR_W-1:0] dr_reg, dr_next;
    logic [3:0]      add_idx_reg, add_idx_next;
    logic            done_reg, done_next;
    logic [1:0]      amt [4];
    logic [1:0]      col;

    word_t u_x, u_y, u_z, u_sum, u_mixed;
    rot_t  u_rot;
    word_t sel_word;

    // Input state of the block function.
    always_comb
    begin
        init_w[0]  = SIGMA0;
        init_w[1]  = SIGMA1;
        init_w[2]  = SIGMA2;
        init_w[3]  = SIGMA3;
        for (int m = 0; m < 8; m++)
        begin
            init_w[4 + m] = key[32*m +: 32];
        end
        init_w[12] = count[31:0];
        init_w[13] = count[63:32];
        init_w[14] = nonce[31:0];
        init_w[15] = nonce[63:32];
    end

    cc20_qr_unit u_step (
        .x     (u_x),
        .y     (u_y),
        .z     (u_z),
        .rot   (u_rot),
        .sum   (u_sum),
        .mixed (u_mixed)
    );

    // The unit always works on column 0; even steps update a and d,
    // odd steps update c and b. The add-back pass streams word 0 through it.
    always_comb
    begin
        if (state_reg == C_ADD)
        begin
            u_x   = w_reg[0];
            u_y   = init_w[add_idx_reg];
            u_z   = w_reg[12];
            u_rot = ROT16;
        end
        else if (!step_reg[0])
        begin
            u_x   = w_reg[0];
            u_y   = w_reg[4];
            u_z   = w_reg[12];
            u_rot = step_reg[1] ? ROT8 : ROT16;
        end
        else
        begin
            u_x   = w_reg[8];
            u_y   = w_reg[12];
            u_z   = w_reg[4];
            u_rot = step_reg[1] ? ROT7 : ROT12;
        end
    end

    // Row rotations after each quarter round bring the next column (or
    // diagonal) into column 0. At the end of a column round the rows are
    // also diagonalized; at the end of a diagonal round they are restored.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            if (qr_reg == 2'd3 && !half_reg)
            begin
                amt[r] = 2'(r + 1);
            end
            else if (qr_reg == 2'd3 && half_reg)
            begin
                amt[r] = 2'(5 - r);
            end
            else
            begin
                amt[r] = 2'd1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            upd[i] = w_reg[i];
        end
        if (!step_reg[0])
        begin
            upd[0]  = u_sum;
            upd[12] = u_mixed;
        end
        else
        begin
            upd[8] = u_sum;
            upd[4] = u_mixed;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        qr_next      = qr_reg;
        half_next    = half_reg;
        dr_next      = dr_reg;
        add_idx_next = add_idx_reg;
        done_next    = 1'b0;
        col          = 2'd0;
        for (int i = 0; i < 16; i++)
        begin
            w_next[i] = w_reg[i];
        end

        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        w_next[i] = init_w[i];
                    end
                    step_next  = 2'd0;
                    qr_next    = 2'd0;
                    half_next  = 1'b0;
                    dr_next    = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg != 2'd3)
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        w_next[i] = upd[i];
                    end
                end
                else
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            col = 2'(j) + amt[r];
                            w_next[4*r + j] = upd[{2'(r), col}];
                        end
                    end
                    qr_next = qr_reg + 2'd1;
                    if (qr_reg == 2'd3)
                    begin
                        half_next = ~half_reg;
                        if (half_reg)
                        begin
                            dr_next = dr_reg + DR_W'(1);
                            if (dr_reg == DR_W'(DOUBLE_ROUNDS - 1))
                            begin
                                add_idx_next = 4'd0;
                                state_next   = C_ADD;
                            end
                        end
                    end
                end
            end
            C_ADD:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15]   = u_sum;
                add_idx_next = add_idx_reg + 4'd1;
                if (add_idx_reg == 4'd15)
                begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= C_IDLE;
            step_reg    <= 2'd0;
            qr_reg      <= 2'd0;
            half_reg    <= 1'b0;
            dr_reg      <= '0;
            add_idx_reg <= 4'd0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            qr_reg      <= qr_next;
            half_reg    <= half_next;
            dr_reg      <= dr_next;
            add_idx_reg <= add_idx_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_reg[i] <= w_next[i];
        end
    end

    assign sel_word = w_reg[byte_sel[5:2]];
    assign byte_out = sel_word[8*byte_sel[1:0] +: 8];
    assign done     = done_reg;

endmodule

FILE: hw/rtl/chacha20_stream_cipher.sv
// ChaCha20 stream cipher, 64-bit counter and 64-bit nonce, one byte per request.
// Depends on cc20_pkg and cc20_core (which uses cc20_qr_unit).
//
// Usage: write the key, nonce and start counter through the cfg_write port
// (cfg_index selects the register, cfg_data carries the value) while the block
// is idle. Each request on the plain channel (plain_valid, plain_stall, plain)
// carries one byte and a last mark; the block answers with exactly one request
// on the crypt channel holding the byte XORed with keystream, the last mark
// and the sticky counter-wrap flag.
// A byte taken from an already generated keystream block is XORed and written straight into the result register.
// When the 64-byte block is used up, or at the first byte of a message, a new
// block is made by one shared quarter-round step unit: one add/xor/rotate per
// cycle through all rounds and then the add-back of the input state, after which
// the held byte is handed to the result register. No new byte is taken while a
// block is being generated.
// The output register frees the input side: a new byte is taken while the
// previous result waits if the receiver takes it in the same cycle. While
// crypt_stall holds, the result stays in place and plain_stall is raised.
// Reset clears the configuration, the counter and the wrap flag, empties the
// result register and arms the first byte as a message start.
`timescale 1ns / 1ps

module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cc20_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                plain_valid,
    output logic                                plain_stall,
    input  cc20_pkg::plain_t                    plain,
    output logic                                crypt_valid,
    input  logic                                crypt_stall,
    output cc20_pkg::crypt_t                    crypt
);
    import cc20_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE,
        T_GEN,
        T_EMIT
    } top_state_t;

    top_state_t  state_reg, state_next;
    logic [63:0] key_reg [4];
    logic [63:0] key_next [4];
    logic [63:0] nonce_reg, nonce_next;
    logic [63:0] start_cnt_reg, start_cnt_next;
    logic [63:0] count_reg, count_next;
    logic [6:0]  pos_reg, pos_next;
    logic        wrap_reg, wrap_next;
    logic        msg_start_reg, msg_start_next;
    logic        out_valid_reg, out_valid_next;
    crypt_t      out_reg, out_next;
    plain_t      hold_reg, hold_next;

    logic        out_free;
    logic        accept;
    logic        core_start;
    logic        core_done;
    logic [63:0] core_count;
    logic [5:0]  byte_sel;
    logic [7:0]  ks_byte;
    logic [63:0] count_inc;

    // The result register can take a new value when empty or being drained.
    assign out_free    = !out_valid_reg || !crypt_stall;
    assign plain_stall = !((state_reg == T_IDLE) && out_free);
    assign accept      = plain_valid && !plain_stall;

    // At a message start the counter is reloaded in the same cycle that the
    // block generation begins, so the core sees the configured value directly.
    assign core_count = (state_reg == T_IDLE && msg_start_reg) ? start_cnt_reg : count_reg;
    assign byte_sel   = (state_reg == T_IDLE) ? pos_reg[5:0] : 6'd0;
    assign count_inc  = count_reg + 64'd1;

    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (core_start),
        .key      ({key_reg[3], key_reg[2], key_reg[1], key_reg[0]}),
        .nonce    (nonce_reg),
        .count    (core_count),
        .byte_sel (byte_sel),
        .byte_out (ks_byte),
        .done     (core_done)
    );

    // Configuration writes; indexes past the register list are ignored.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            key_next[i] = key_reg[i];
        end
        nonce_next     = nonce_reg;
        start_cnt_next = start_cnt_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KEY0:      key_next[0]    = cfg_data;
                CFG_KEY1:      key_next[1]    = cfg_data;
                CFG_KEY2:      key_next[2]    = cfg_data;
                CFG_KEY3:      key_next[3]    = cfg_data;
                CFG_NONCE:     nonce_next     = cfg_data;
                CFG_START_CNT: start_cnt_next = cfg_data;
                default:       ;
            endcase
        end
    end

    // Request flow: bytes inside a filled keystream block are answered at
    // once; otherwise the byte is held while a new block is generated.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        wrap_next      = wrap_reg;
        msg_start_next = msg_start_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && crypt_stall;
        core_start     = 1'b0;

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    msg_start_next = plain.last_in;
                    if (msg_start_reg)
                    begin
                        count_next = start_cnt_reg;
                    end
                    if (msg_start_reg || pos_reg[6])
                    begin
                        hold_next  = plain;
                        core_start = 1'b1;
                        state_next = T_GEN;
                    end
                    else
                    begin
                        out_next.data_out        = plain.data_in ^ ks_byte;
                        out_next.last_out        = plain.last_in;
                        out_next.counter_wrapped = wrap_reg;
                        out_valid_next           = 1'b1;
                        pos_next                 = pos_reg + 7'd1;
                    end
                end
            end
            T_GEN:
            begin
                if (core_done)
                begin
                    count_next = count_inc;
                    if (count_inc == 64'd0)
                    begin
                        wrap_next = 1'b1;
                    end
                    state_next = T_EMIT;
                end
            end
            T_EMIT:
            begin
                if (out_free)
                begin
                    out_next.data_out        = hold_reg.data_in ^ ks_byte;
                    out_next.last_out        = hold_reg.last_in;
                    out_next.counter_wrapped = wrap_reg;
                    out_valid_next           = 1'b1;
                    pos_next                 = 7'd1;
                    state_next               = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= 64'd0;
            end
            nonce_reg     <= 64'd0;
            start_cnt_reg <= 64'd0;
            count_reg     <= 64'd0;
            pos_reg       <= 7'd64;
            wrap_reg      <= 1'b0;
            msg_start_reg <= 1'b1;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= key_next[i];
            end
            nonce_reg     <= nonce_next;
            start_cnt_reg <= start_cnt_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            wrap_reg      <= wrap_next;
            msg_start_reg <= msg_start_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // The held byte is payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign crypt_valid = out_valid_reg;
    assign crypt       = out_reg;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for chacha20_stream_cipher: directed rows, then random messages.
// Checks every crypt request against its ChaCha20 keystream generator or pinned fields.
// Depends on cc20_pkg and the RTL of chacha20_stream_cipher.
`timescale 1ns / 1ps

module tb_top;

    import cc20_pkg::*;

    localparam int ROUNDS       = 10;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 32 * ROUNDS + 80;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 4000;

    // Register indexes past the last real register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

    // ChaCha "expand 32-byte k" constants, kept apart from the package on purpose.
    localparam word_t EXPAND0 = 32'h61707865;
    localparam word_t EXPAND1 = 32'h3320646e;
    localparam word_t EXPAND2 = 32'h79622d32;
    localparam word_t EXPAND3 = 32'h6b206574;

    // How a directed row is checked: a register write, predictor only, pinned last and
    // wrap flags with predicted data, or every field pinned.
    typedef enum logic [1:0] {
        ROW_REG,
        ROW_BYTE,
        ROW_FLAGS,
        ROW_FULL
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      val;
        plain_t                item;
        crypt_t                want;
    } script_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  plain_valid;
    logic                  plain_stall;
    plain_t                plain;
    logic                  crypt_valid;
    logic                  crypt_stall;
    crypt_t                crypt;

    // Keystream generator state.
    logic [CFG_W-1:0]  cipher_regs [0:5];
    logic [63:0]       blk_ctr;
    logic [7:0]        ks_buf [0:63];
    logic [6:0]        ks_pos;
    logic              wrap_seen;
    logic              msg_fresh;
    word_t             mix_w [0:15];

    crypt_t       crypt_due [$];
    script_row_t  script [$];
    crypt_t       want;
    int           mismatches;
    int           items_sent;
    bit           no_idle;
    bit           hold_long;

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS(ROUNDS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .plain_valid (plain_valid),
        .plain_stall (plain_stall),
        .plain       (plain),
        .crypt_valid (crypt_valid),
        .crypt_stall (crypt_stall),
        .crypt       (crypt)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic word_t rotl(word_t v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void quarter_mix(int a, int b, int c, int d);
        mix_w[a] = mix_w[a] + mix_w[b];
        mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 16);
        mix_w[c] = mix_w[c] + mix_w[d];
        mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 12);
        mix_w[a] = mix_w[a] + mix_w[b];
        mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 8);
        mix_w[c] = mix_w[c] + mix_w[d];
        mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 7);
    endfunction

    // Builds the next 64 keystream bytes from the current key, nonce and counter,
    // then steps the counter and latches the wrap flag when it rolls over to zero.
    function automatic void refill_keystream();
        word_t seed [0:15];
        word_t sum;
        int i;
        int r;
        seed[0] = EXPAND0;
        seed[1] = EXPAND1;
        seed[2] = EXPAND2;
        seed[3] = EXPAND3;
        for (i = 0; i < 4; i++)
        begin
            seed[4 + 2 * i] = cipher_regs[CFG_KEY0 + i][31:0];
            seed[5 + 2 * i] = cipher_regs[CFG_KEY0 + i][63:32];
        end
        seed[12] = blk_ctr[31:0];
        seed[13] = blk_ctr[63:32];
        seed[14] = cipher_regs[CFG_NONCE][31:0];
        seed[15] = cipher_regs[CFG_NONCE][63:32];
        for (i = 0; i < 16; i++)
            mix_w[i] = seed[i];
        for (r = 0; r < ROUNDS; r++)
        begin
            quarter_mix(0, 4, 8, 12);
            quarter_mix(1, 5, 9, 13);
            quarter_mix(2, 6, 10, 14);
            quarter_mix(3, 7, 11, 15);
            quarter_mix(0, 5, 10, 15);
            quarter_mix(1, 6, 11, 12);
            quarter_mix(2, 7, 8, 13);
            quarter_mix(3, 4, 9, 14);
        end
        for (i = 0; i < 16; i++)
        begin
            sum = mix_w[i] + seed[i];
            ks_buf[4 * i]     = sum[7:0];
            ks_buf[4 * i + 1] = sum[15:8];
            ks_buf[4 * i + 2] = sum[23:16];
            ks_buf[4 * i + 3] = sum[31:24];
        end
        blk_ctr = blk_ctr + 64'd1;
        if (blk_ctr == 64'd0)
            wrap_seen = 1'b1;
    endfunction

    // Result the block owes for one accepted plain request.
    function automatic crypt_t cipher_byte(plain_t p);
        crypt_t r;
        if (msg_fresh)
        begin
            blk_ctr   = cipher_regs[CFG_START_CNT];
            ks_pos    = 7'd64;
            msg_fresh = 1'b0;
        end
        if (ks_pos >= 7'd64)
        begin
            refill_keystream();
            ks_pos = 7'd0;
        end
        r.data_out = p.data_in ^ ks_buf[ks_pos[5:0]];
        ks_pos     = ks_pos + 7'd1;
        if (p.last_in)
            msg_fresh = 1'b1;
        r.last_out        = p.last_in;
        r.counter_wrapped = wrap_seen;
        return r;
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        script_row_t r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.val  = val;
        script.push_back(r);
    endfunction

    // last_out is always a copy of last_in, so it is pinned from the row itself.
    function automatic void add_row(row_kind_t k, logic [7:0] d, logic l,
                                    logic [7:0] want_d, logic want_w);
        script_row_t r;
        r                      = '0;
        r.kind                 = k;
        r.item.data_in         = d;
        r.item.last_in         = l;
        r.want.data_out        = want_d;
        r.want.last_out        = l;
        r.want.counter_wrapped = want_w;
        script.push_back(r);
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'h0000_0000_ffff_ffff;
            3: return 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic flag_mismatch(string what, int got, int expected);
        $display("%0t mismatch on %s: got %0h, wanted %0h", $realtime, what, got, expected);
        mismatches++;
    endtask

    // Leaves cfg_write high so that back-to-back writes never lower and raise it
    // in one step; the caller drops it once the batch is done.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx <= CFG_START_CNT)
            cipher_regs[idx] = val;
    endtask

    // Withdraw the plain request and wait until every owed result has come back.
    task automatic settle();
        plain_valid <= 1'b0;
        @(posedge clk);
        while (crypt_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_byte(plain_t p, row_kind_t k, crypt_t pin);
        int gap;
        crypt_t due;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            plain_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        plain_valid <= 1'b1;
        plain       <= p;
        do
            @(posedge clk);
        while (plain_stall);
        due = cipher_byte(p);
        if (k == ROW_FULL)
            due = pin;
        else if (k == ROW_FLAGS)
        begin
            due.last_out        = pin.last_out;
            due.counter_wrapped = pin.counter_wrapped;
        end
        crypt_due.push_back(due);
        items_sent++;
    endtask

    // Receiver: stalls each crypt request for a drawn number of cycles, once for a
    // long stretch so that the output register fills and the input side backs up.
    initial
    begin
        int hold;
        crypt_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold      = hold_long ? LONG_HOLD : (no_idle ? 0 : $urandom_range(0, 11));
            hold_long = 1'b0;
            if (hold > 0)
            begin
                crypt_stall <= 1'b1;
                do
                    @(posedge clk);
                while (!crypt_valid);
                repeat (hold - 1) @(posedge clk);
                crypt_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!crypt_valid);
        end
    end

    // Every accepted crypt request is matched against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && crypt_valid === 1'b1 && crypt_stall === 1'b0)
        begin
            if (crypt_due.size() == 0)
                flag_mismatch("unexpected crypt request", crypt, 0);
            else
            begin
                want = crypt_due.pop_front();
                if (crypt.data_out !== want.data_out)
                    flag_mismatch("data_out", crypt.data_out, want.data_out);
                if (crypt.last_out !== want.last_out)
                    flag_mismatch("last_out", crypt.last_out, want.last_out);
                if (crypt.counter_wrapped !== want.counter_wrapped)
                    flag_mismatch("counter_wrapped", crypt.counter_wrapped,
                                  want.counter_wrapped);
            end
        end
    end

    // Ends the run if neither channel nor the register port moves for too long.
    initial
    begin : watchdog
        int dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((plain_valid && !plain_stall) || (crypt_valid && !crypt_stall) || cfg_write)
                dead_cycles = 0;
            else
                dead_cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        int i;
        int phase;
        int n_msgs;
        int m;
        int len;
        int j;
        int k;
        bit leave_open;
        plain_t p;

        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= CFG_KEY0;
        cfg_data    <= '0;
        plain_valid <= 1'b0;
        plain       <= '0;
        mismatches  = 0;
        items_sent  = 0;
        no_idle     = 1'b0;
        hold_long   = 1'b0;
        for (i = 0; i < 6; i++)
            cipher_regs[i] = '0;
        for (i = 0; i < 64; i++)
            ks_buf[i] = '0;
        blk_ctr   = '0;
        ks_pos    = 7'd64;
        wrap_seen = 1'b0;
        msg_fresh = 1'b1;

        // After reset key, nonce and counter are zero, so the first block is the
        // well-known all-zero ChaCha20 keystream: 76 b8 e0 ad a0 f1 3d 90 ...
        add_row(ROW_FULL, 8'h00, 1'b0, 8'h76, 1'b0);
        add_row(ROW_FULL, 8'h00, 1'b0, 8'hb8, 1'b0);
        add_row(ROW_FULL, 8'h00, 1'b0, 8'he0, 1'b0);
        add_row(ROW_FULL, 8'h00, 1'b0, 8'had, 1'b0);
        add_row(ROW_FULL, 8'hff, 1'b0, 8'h5f, 1'b0);
        add_row(ROW_FULL, 8'hff, 1'b0, 8'h0e, 1'b0);
        add_row(ROW_FULL, 8'hff, 1'b0, 8'hc2, 1'b0);
        add_row(ROW_FULL, 8'hff, 1'b1, 8'h6f, 1'b0);
        // A one-byte message: the counter reloads, so the keystream starts over.
        add_row(ROW_FULL, 8'h00, 1'b1, 8'h76, 1'b0);
        add_row(ROW_FULL, 8'h80, 1'b0, 8'hf6, 1'b0);
        // Key and nonce at top value, start counter 2^32 - 1, with a message open;
        // the open message keeps its buffered keystream, and the start counter only
        // counts from the next message on. The spare indexes must change nothing.
        add_reg(CFG_KEY0, '1);
        add_reg(CFG_KEY1, '1);
        add_reg(CFG_KEY2, '1);
        add_reg(CFG_KEY3, '1);
        add_reg(CFG_NONCE, '1);
        add_reg(CFG_START_CNT, 64'h0000_0000_ffff_ffff);
        add_reg(CFG_SPARE6, '1);
        add_reg(CFG_SPARE7, 64'h5a5a_a5a5_0f0f_f0f0);
        add_row(ROW_BYTE, 8'h55, 1'b0, 8'h00, 1'b0);
        add_row(ROW_BYTE, 8'haa, 1'b1, 8'h00, 1'b0);
        add_row(ROW_BYTE, 8'h01, 1'b0, 8'h00, 1'b0);
        add_row(ROW_BYTE, 8'hfe, 1'b1, 8'h00, 1'b0);
        // Start counter at its maximum: the first block rolls the counter over and
        // the wrap flag comes up with that very byte and stays up.
        add_reg(CFG_KEY0, 64'h0706_0504_0302_0100);
        add_reg(CFG_KEY1, 64'h0f0e_0d0c_0b0a_0908);
        add_reg(CFG_KEY2, '0);
        add_reg(CFG_KEY3, 64'h8000_0000_0000_0001);
        add_reg(CFG_NONCE, '0);
        add_reg(CFG_START_CNT, '1);
        add_row(ROW_FLAGS, 8'h3c, 1'b0, 8'h00, 1'b1);
        add_row(ROW_FLAGS, 8'hc3, 1'b1, 8'h00, 1'b1);
        add_row(ROW_FLAGS, 8'h00, 1'b1, 8'h00, 1'b1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows. A run of register rows is preceded by a full drain.
        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
            begin
                if (!cfg_write)
                    settle();
                write_reg(script[i].idx, script[i].val);
            end
            else
            begin
                if (cfg_write)
                    cfg_write <= 1'b0;
                send_byte(script[i].item, script[i].kind, script[i].want);
            end
        end

        // Random phases: drain, rewrite a few registers, then a handful of
        // messages. Most messages are short; some cross one or two block
        // boundaries. Now and then the last message of a phase is left open so the
        // next register writes land in the middle of a message.
        phase = 0;
        while (items_sent < script.size() + RANDOM_ITEMS)
        begin
            settle();
            repeat ($urandom_range(1, 4))
                write_reg(CFG_IDX_W'($urandom_range(0, 7)), pick_reg_value());
            cfg_write <= 1'b0;
            no_idle = ($urandom_range(0, 3) == 0) || (phase == 3);
            if (phase == 3)
                hold_long = 1'b1;
            n_msgs = $urandom_range(2, 5);
            for (m = 0; m < n_msgs; m++)
            begin
                k = $urandom_range(0, 9);
                if (k < 7)
                    len = $urandom_range(1, 12);
                else if (k < 9)
                    len = $urandom_range(13, 63);
                else
                    len = $urandom_range(64, 150);
                leave_open = (m == n_msgs - 1) && ($urandom_range(0, 4) == 0);
                for (j = 0; j < len; j++)
                begin
                    p.data_in = 8'($urandom_range(0, 255));
                    p.last_in = (j == len - 1) && !leave_open;
                    send_byte(p, ROW_BYTE, '0);
                end
            end
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && crypt_due.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/cc20_pkg.sv
hw/rtl/cc20_qr_unit.sv
hw/rtl/cc20_core.sv
hw/rtl/chacha20_stream_cipher.sv
test/tb_top.sv
